FILE: src/mte_pkg.sv
package mte_pkg;

   localparam int MAX_CHARS_DEF = 32;

   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_COMMIT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   localparam logic [3:0] KEY_0    = 4'd0;
   localparam logic [3:0] KEY_1    = 4'd1;
   localparam logic [3:0] KEY_9    = 4'd9;
   localparam logic [3:0] KEY_STAR = 4'd10;
   localparam logic [3:0] KEY_HASH = 4'd11;
   localparam logic [3:0] KEY_DEL  = 4'd12;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_APPEND   = 3'd1;
   localparam logic [2:0] ACT_REPLACE  = 3'd2;
   localparam logic [2:0] ACT_DELETE   = 3'd3;
   localparam logic [2:0] ACT_CLEAR    = 3'd4;
   localparam logic [2:0] ACT_READ     = 3'd5;

   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'd32;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] char_out;
      logic [4:0] position;
      logic [5:0] length;
   } result_type;

   function automatic logic [2:0] tap_len(input logic [3:0] key);
      case (key)
         4'd0:    tap_len = 3'd2;
         4'd7:    tap_len = 3'd5;
         4'd9:    tap_len = 3'd5;
         default: tap_len = 3'd4;
      endcase
   endfunction

   function automatic logic [7:0] tap_char(input logic [3:0] key, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (key)
         4'd0: case (idx)
                  3'd0:    c = " ";
                  3'd1:    c = "0";
                  default: c = 8'h00;
               endcase
         4'd2: case (idx)
                  3'd0: c = "a"; 3'd1: c = "b"; 3'd2: c = "c"; 3'd3: c = "2";
                  default: c = 8'h00;
               endcase
         4'd3: case (idx)
                  3'd0: c = "d"; 3'd1: c = "e"; 3'd2: c = "f"; 3'd3: c = "3";
                  default: c = 8'h00;
               endcase
         4'd4: case (idx)
                  3'd0: c = "g"; 3'd1: c = "h"; 3'd2: c = "i"; 3'd3: c = "4";
                  default: c = 8'h00;
               endcase
         4'd5: case (idx)
                  3'd0: c = "j"; 3'd1: c = "k"; 3'd2: c = "l"; 3'd3: c = "5";
                  default: c = 8'h00;
               endcase
         4'd6: case (idx)
                  3'd0: c = "m"; 3'd1: c = "n"; 3'd2: c = "o"; 3'd3: c = "6";
                  default: c = 8'h00;
               endcase
         4'd7: case (idx)
                  3'd0: c = "p"; 3'd1: c = "q"; 3'd2: c = "r"; 3'd3: c = "s";
                  3'd4: c = "7";
                  default: c = 8'h00;
               endcase
         4'd8: case (idx)
                  3'd0: c = "t"; 3'd1: c = "u"; 3'd2: c = "v"; 3'd3: c = "8";
                  default: c = 8'h00;
               endcase
         4'd9: case (idx)
                  3'd0: c = "w"; 3'd1: c = "x"; 3'd2: c = "y"; 3'd3: c = "z";
                  3'd4: c = "9";
                  default: c = 8'h00;
               endcase
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] direct_char(input logic [3:0] key);
      if (key == KEY_STAR) return "*";
      if (key == KEY_HASH) return "#";
      return 8'h30 + {4'd0, key};
   endfunction

endpackage

FILE: src/multitap_text_entry.sv
// An accepted req goes through the decode/store stage, then the output register, to rsp.
// Throughput: one item per cycle; the store has one write and one registered read port.
// A result held on rsp stalls req only once the decode stage is also occupied.
// Reset (synchronous, active high) empties the store, ends the pending tap,
// sets entry_mode to text entry and drops both result stages. No clearing pass.
module multitap_text_entry
   import mte_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // entry_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // key[3:0], upper_case[4], index[9:5], zero[15:10]
   input  logic [1:0]  req_tuser,     // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // char_out[7:0], position[12:8], length[18:13], zero
   output logic [2:0]  rsp_tuser      // action[2:0]
);

   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int LW = $clog2(MAX_CHARS + 1);
   localparam logic [LW-1:0] FULL_LEN = LW'(MAX_CHARS);

   logic [3:0] key;
   logic       upper;
   logic [4:0] idx;
   logic [1:0] kind;
   assign key   = req_tdata[3:0];
   assign upper = req_tdata[4];
   assign idx   = req_tdata[9:5];
   assign kind  = req_tuser;

   logic [LW-1:0] len_ff, len_in;
   logic          pend_ff, pend_in;
   logic [3:0]    last_key_ff, last_key_in;
   logic [2:0]    tap_idx_ff, tap_idx_in;
   logic          mode_ff;

   logic [7:0]    mem_ff [MAX_CHARS];
   logic [7:0]    mem_rd_ff;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic          rd_hit;

   result_type    res;
   result_type    s1_res_ff;
   logic          s1_valid_ff;
   logic          s1_hit_ff;
   result_type    out_res_ff;
   logic          out_valid_ff;

   logic s1_adv, accept, full, repeat_tap;
   logic [2:0] next_tap;
   logic [7:0] ch;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign full       = (len_ff >= FULL_LEN);
   assign repeat_tap = pend_ff && (key == last_key_ff) && (len_ff != '0);
   assign rd_addr    = AW'(idx);
   assign rd_hit     = ({{(LW > 5 ? LW - 5 : 0){1'b0}}, idx} < len_ff)
                       && (int'(idx) < MAX_CHARS);

   always_comb begin
      len_in      = len_ff;
      pend_in     = pend_ff;
      last_key_in = last_key_ff;
      tap_idx_in  = tap_idx_ff;
      mem_we      = 1'b0;
      wr_addr     = AW'(len_ff);
      wr_data     = 8'h00;
      rd_en       = 1'b0;
      res         = '{action: ACT_NONE, char_out: 8'h00, position: 5'd0, length: 6'd0};
      next_tap    = 3'd0;
      ch          = 8'h00;
      unique case (kind)
         KIND_KEY: begin
            if (mode_ff) begin
               pend_in = 1'b0;
            end
            if (key == KEY_DEL) begin
               if (len_ff != '0) begin
                  len_in       = len_ff - 1'b1;
                  pend_in      = 1'b0;
                  res.action   = ACT_DELETE;
                  res.position = 5'(len_ff - 1'b1);
               end
            end else if (key > KEY_HASH) begin
               res.action = ACT_NONE;
            end else if (mode_ff || key == KEY_1 || key == KEY_STAR || key == KEY_HASH) begin
               if (!full) begin
                  pend_in      = 1'b0;
                  mem_we       = 1'b1;
                  wr_data      = direct_char(key);
                  len_in       = len_ff + 1'b1;
                  res.action   = ACT_APPEND;
                  res.char_out = wr_data;
                  res.position = 5'(len_ff);
               end
            end else if (repeat_tap || !full) begin
               if (repeat_tap) begin
                  next_tap = (tap_idx_ff + 3'd1 >= tap_len(key)) ? 3'd0 : tap_idx_ff + 3'd1;
               end
               tap_idx_in  = next_tap;
               pend_in     = 1'b1;
               last_key_in = key;
               ch = tap_char(key, next_tap);
               if (upper && ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
                  ch = ch - CASE_DIFF;
               end
               mem_we       = 1'b1;
               wr_data      = ch;
               res.char_out = ch;
               if (repeat_tap) begin
                  wr_addr      = AW'(len_ff - 1'b1);
                  res.action   = ACT_REPLACE;
                  res.position = 5'(len_ff - 1'b1);
               end else begin
                  len_in       = len_ff + 1'b1;
                  res.action   = ACT_APPEND;
                  res.position = 5'(len_ff);
               end
            end
         end
         KIND_COMMIT: begin
            pend_in = 1'b0;
         end
         KIND_CLEAR: begin
            len_in     = '0;
            pend_in    = 1'b0;
            tap_idx_in = 3'd0;
            res.action = ACT_CLEAR;
         end
         KIND_READ: begin
            rd_en        = 1'b1;
            res.action   = ACT_READ;
            res.position = idx;
         end
         default: res.action = ACT_NONE;
      endcase
      res.length = 6'(len_in);
   end

   // entries at or above the length are never returned, so the store needs no clearing
   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (accept && rd_en && rd_hit) begin
         mem_rd_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         last_key_ff  <= 4'd0;
         tap_idx_ff   <= 3'd0;
         mode_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            len_ff      <= len_in;
            pend_ff     <= pend_in;
            last_key_ff <= last_key_in;
            tap_idx_ff  <= tap_idx_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= res;
         s1_hit_ff <= rd_en && rd_hit;
      end
      if (s1_adv) begin
         out_res_ff <= '{action:   s1_res_ff.action,
                         char_out: s1_hit_ff ? mem_rd_ff : s1_res_ff.char_out,
                         position: s1_res_ff.position,
                         length:   s1_res_ff.length};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.action;
   assign rsp_tdata  = {5'd0, out_res_ff.length, out_res_ff.position, out_res_ff.char_out};

endmodule

FILE: src/mte_checker.sv
module mte_checker
   import mte_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled item changed");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_CLEAR
         |-> rsp_tdata[18:13] == 6'd0 && rsp_tdata[7:0] == 8'd0)
      else $error("clear item not empty");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_NONE |-> rsp_tdata[12:0] == 13'd0)
      else $error("no-change item carries data");

endmodule

bind multitap_text_entry mte_checker u_mte_checker (.*);
